### design/evad_pkg.sv
// ----------------------------------------------------------------------------
// evad_pkg
// Types and constants shared by the energy voice activity detector modules.
// ----------------------------------------------------------------------------
package evad_pkg;

	// Input request: one PCM sample and its frame marks.
	typedef struct packed {
		logic signed [15:0] sample;
		logic               sample_valid;
		logic               frame_end;
	} in_item_t;

	// Result request: one per non-empty frame.
	typedef struct packed {
		logic active;
		logic speech_start;
		logic speech_end;
		logic frame_is_speech;
		logic overflow;
	} out_item_t;

	// Request passed from the front to the back part.
	typedef struct packed {
		logic               acc;
		logic               div3;
		logic               fend;
		logic signed [17:0] value;
	} mid_item_t;

	// Configuration register file.
	typedef struct packed {
		logic        rate_is_48k;
		logic [15:0] min_speech_count;
		logic [15:0] min_silence_count;
		logic [30:0] speech_level;
	} cfg_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_IS_48K       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SILENCE_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEECH_LEVEL      = 2'd3;

	localparam logic        RST_RATE_IS_48K       = 1'b0;
	localparam logic [15:0] RST_MIN_SPEECH_COUNT  = 16'd10;
	localparam logic [15:0] RST_MIN_SILENCE_COUNT = 16'd25;
	localparam logic [30:0] RST_SPEECH_LEVEL      = 31'd107374;

	// Division by three: (x * 43691) >> 17 is exact for 0 <= x <= 98304.
	localparam logic [15:0] DIV3_RECIP = 16'd43691;
	localparam int          DIV3_SHIFT = 17;

	localparam logic [15:0] RUN_MAX = 16'hFFFF;

	localparam logic [1:0] GROUP_LAST = 2'd2;

endpackage

### design/energy_voice_activity_detector.sv
// A frame-end request goes through the input queue, back stages and result queue.
// Throughput: one request per cycle; the back pipeline holds only while its
// four-entry result queue is full, and the input queue then fills behind it.
// Reset clears the accumulators, run counters and segment state, empties both
// queues and returns the configuration registers to their default values.
// ----------------------------------------------------------------------------
// energy_voice_activity_detector
// Frame energy voice activity detector with optional 48 kHz to 16 kHz
// averaging, run counters and speech start and end events.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector #(
	parameter int FRAME_MAX = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  evad_pkg::in_item_t                  item,
	output logic                                full,
	input  logic                                pop,
	output logic                                empty,
	output evad_pkg::out_item_t                 result,
	input  logic                                cfg_wr_en,
	input  logic [evad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [evad_pkg::CFG_DATA_W-1:0]     cfg_data
);
	evad_pkg::cfg_t      cfg_q;
	logic                mid_valid;
	logic                mid_pop;
	evad_pkg::mid_item_t mid_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_is_48k       <= evad_pkg::RST_RATE_IS_48K;
			cfg_q.min_speech_count  <= evad_pkg::RST_MIN_SPEECH_COUNT;
			cfg_q.min_silence_count <= evad_pkg::RST_MIN_SILENCE_COUNT;
			cfg_q.speech_level      <= evad_pkg::RST_SPEECH_LEVEL;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				evad_pkg::REG_RATE_IS_48K:       cfg_q.rate_is_48k       <= cfg_data[0];
				evad_pkg::REG_MIN_SPEECH_COUNT:  cfg_q.min_speech_count  <= cfg_data[15:0];
				evad_pkg::REG_MIN_SILENCE_COUNT: cfg_q.min_silence_count <= cfg_data[15:0];
				evad_pkg::REG_SPEECH_LEVEL:      cfg_q.speech_level      <= cfg_data[30:0];
				default:                         cfg_q <= cfg_q;
			endcase
		end
	end

	evad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rate_is_48k(cfg_q.rate_is_48k),
		.push       (push),
		.item       (item),
		.full       (full),
		.mid_pop    (mid_pop),
		.mid_valid  (mid_valid),
		.mid_item   (mid_item)
	);

	evad_back #(
		.FRAME_MAX(FRAME_MAX)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.mid_valid(mid_valid),
		.mid_item (mid_item),
		.mid_pop  (mid_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	// The back part only takes a request that the front part offers.
	a_mid_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> mid_valid)
		else $error("back part took a request from an empty queue");

	// A start without an end leaves the segment active.
	a_start_active: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.speech_start && !result.speech_end |-> result.active)
		else $error("speech start without active segment");

	// An end always leaves the segment inactive.
	a_end_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.speech_end |-> !result.active)
		else $error("speech end with segment still active");

endmodule

### design/evad_fifo.sv
// ----------------------------------------------------------------------------
// evad_fifo
// Small register-based first-in first-out queue.
// ----------------------------------------------------------------------------
module evad_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/evad_front.sv
// ----------------------------------------------------------------------------
// evad_front
// Accepts sample requests, forms three-sample groups in 48 kHz mode and
// queues accumulate and frame-end requests for the back part.
// ----------------------------------------------------------------------------
module evad_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rate_is_48k,
	input  logic                push,
	input  evad_pkg::in_item_t  item,
	output logic                full,
	input  logic                mid_pop,
	output logic                mid_valid,
	output evad_pkg::mid_item_t mid_item
);
	localparam int MW = $bits(evad_pkg::mid_item_t);

	logic signed [17:0]  group_sum_q;
	logic [1:0]          group_phase_q;
	logic signed [17:0]  sample_ext;
	logic signed [17:0]  sum_next;
	logic                group_done;
	logic                accept;
	logic                mid_empty;
	logic [MW-1:0]       mid_rd;
	evad_pkg::mid_item_t wr_item;

	assign accept     = push && !full;
	assign sample_ext = 18'(item.sample);
	assign sum_next   = group_sum_q + sample_ext;
	assign group_done = (group_phase_q == evad_pkg::GROUP_LAST);

	always_comb begin
		wr_item.acc   = item.sample_valid && (!rate_is_48k || group_done);
		wr_item.div3  = rate_is_48k;
		wr_item.fend  = item.frame_end;
		wr_item.value = rate_is_48k ? sum_next : sample_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_sum_q   <= '0;
			group_phase_q <= '0;
		end else if (accept) begin
			// A frame end drops any partial group.
			if (item.frame_end || (item.sample_valid && rate_is_48k && group_done)) begin
				group_sum_q   <= '0;
				group_phase_q <= '0;
			end else if (item.sample_valid && rate_is_48k) begin
				group_sum_q   <= sum_next;
				group_phase_q <= group_phase_q + 1'b1;
			end
		end
	end

	evad_fifo #(
		.WIDTH(MW),
		.DEPTH(4)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && (wr_item.acc || wr_item.fend)),
		.wr_data(MW'(wr_item)),
		.rd_en  (mid_pop),
		.rd_data(mid_rd),
		.full   (full),
		.empty  (mid_empty)
	);

	assign mid_valid = !mid_empty;
	assign mid_item  = evad_pkg::mid_item_t'(mid_rd);

endmodule

### design/evad_back.sv
// ----------------------------------------------------------------------------
// evad_back
// Scales grouped samples, squares and accumulates them, and at frame end
// compares energy against the level and runs the segment state.
// ----------------------------------------------------------------------------
module evad_back #(
	parameter int FRAME_MAX = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  evad_pkg::cfg_t      cfg,
	input  logic                mid_valid,
	input  evad_pkg::mid_item_t mid_item,
	output logic                mid_pop,
	input  logic                pop,
	output logic                empty,
	output evad_pkg::out_item_t result
);
	localparam int CW = $clog2(FRAME_MAX + 1);
	localparam int EW = CW + 30;
	localparam int PW = CW + 31;
	localparam int OW = $bits(evad_pkg::out_item_t);

	logic stall;
	logic out_full;

	// Stage 1: divide a group sum by three in 48 kHz mode, else pass the sample.
	logic               valid_s1;
	logic               acc_s1;
	logic               fend_s1;
	logic signed [15:0] smp_s1;
	logic [16:0]        mag;
	logic [32:0]        div_prod;
	logic [15:0]        quot;
	logic signed [15:0] smp_next;

	// Stage 2: square.
	logic               valid_s2;
	logic               acc_s2;
	logic               fend_s2;
	logic [30:0]        sq_s2;
	logic signed [31:0] sq_full;

	// Frame accumulator.
	logic [EW-1:0] energy_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [EW-1:0] energy_n;
	logic [CW-1:0] count_n;
	logic          ovf_n;
	logic          room;

	// Stage 3: frame snapshot.
	logic          fvalid_s3;
	logic [EW-1:0] energy_s3;
	logic [CW-1:0] count_s3;
	logic          ovf_s3;

	// Stage 4: threshold product.
	logic          fvalid_s4;
	logic [EW-1:0] energy_s4;
	logic [PW-1:0] prod_s4;
	logic          ovf_s4;

	// Segment state.
	logic [15:0] speech_run_q;
	logic [15:0] silence_run_q;
	logic        active_q;
	logic [15:0] speech_run_n;
	logic [15:0] silence_run_n;
	logic        loud_frame;
	logic        start;
	logic        stop;
	logic        active_mid;

	evad_pkg::out_item_t wr_res;
	logic [OW-1:0]       rd_res;

	// The whole pipeline holds while the result queue is full.
	assign stall   = out_full;
	assign mid_pop = mid_valid && !stall;

	always_comb begin
		mag      = mid_item.value[17] ? 17'(-mid_item.value) : mid_item.value[16:0];
		div_prod = 33'(mag) * 33'(evad_pkg::DIV3_RECIP);
		quot     = div_prod[evad_pkg::DIV3_SHIFT +: 16];
		if (!mid_item.div3) begin
			smp_next = mid_item.value[15:0];
		end else if (mid_item.value[17]) begin
			smp_next = -quot;
		end else begin
			smp_next = quot;
		end
	end

	assign sq_full = smp_s1 * smp_s1;

	always_comb begin
		room     = (count_q < CW'(FRAME_MAX));
		energy_n = energy_q;
		count_n  = count_q;
		ovf_n    = ovf_q;
		if (acc_s2) begin
			if (room) begin
				energy_n = energy_q + EW'(sq_s2);
				count_n  = count_q + 1'b1;
			end else begin
				ovf_n = 1'b1;
			end
		end
	end

	always_comb begin
		loud_frame = (PW'(energy_s4) > prod_s4);
		if (loud_frame) begin
			speech_run_n  = (speech_run_q == evad_pkg::RUN_MAX) ? speech_run_q
				: speech_run_q + 1'b1;
			silence_run_n = '0;
		end else begin
			silence_run_n = (silence_run_q == evad_pkg::RUN_MAX) ? silence_run_q
				: silence_run_q + 1'b1;
			speech_run_n  = '0;
		end
		start      = !active_q && (speech_run_n >= cfg.min_speech_count);
		active_mid = active_q || start;
		stop       = active_mid && (silence_run_n >= cfg.min_silence_count);
		wr_res.active          = active_mid && !stop;
		wr_res.speech_start    = start;
		wr_res.speech_end      = stop;
		wr_res.frame_is_speech = loud_frame;
		wr_res.overflow        = ovf_s4;
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			acc_s1    <= mid_item.acc;
			fend_s1   <= mid_item.fend;
			smp_s1    <= smp_next;
			acc_s2    <= acc_s1;
			fend_s2   <= fend_s1;
			sq_s2     <= sq_full[30:0];
			energy_s3 <= energy_n;
			count_s3  <= count_n;
			ovf_s3    <= ovf_n;
			energy_s4 <= energy_s3;
			prod_s4   <= PW'(cfg.speech_level) * PW'(count_s3);
			ovf_s4    <= ovf_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			fvalid_s3     <= 1'b0;
			fvalid_s4     <= 1'b0;
			energy_q      <= '0;
			count_q       <= '0;
			ovf_q         <= 1'b0;
			speech_run_q  <= '0;
			silence_run_q <= '0;
			active_q      <= 1'b0;
		end else if (!stall) begin
			valid_s1  <= mid_pop;
			valid_s2  <= valid_s1;
			fvalid_s3 <= valid_s2 && fend_s2 && (count_n != '0);
			fvalid_s4 <= fvalid_s3;
			if (valid_s2) begin
				// A frame end starts the next frame from zero, empty or not.
				if (fend_s2) begin
					energy_q <= '0;
					count_q  <= '0;
					ovf_q    <= 1'b0;
				end else begin
					energy_q <= energy_n;
					count_q  <= count_n;
					ovf_q    <= ovf_n;
				end
			end
			if (fvalid_s4) begin
				speech_run_q  <= speech_run_n;
				silence_run_q <= silence_run_n;
				active_q      <= wr_res.active;
			end
		end
	end

	evad_fifo #(
		.WIDTH(OW),
		.DEPTH(4)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fvalid_s4 && !stall),
		.wr_data(OW'(wr_res)),
		.rd_en  (pop),
		.rd_data(rd_res),
		.full   (out_full),
		.empty  (empty)
	);

	assign result = evad_pkg::out_item_t'(rd_res);

endmodule
